[hw/rtl/mmgs_pkg.sv]
`timescale 1ns / 1ps
// Shared constants for the min-max gray stretch block.
package mmgs_pkg;

  localparam int QUO_BITS = 8;
  localparam logic [QUO_BITS-1:0] GRAY_MAX = 8'd255;
  localparam logic [QUO_BITS-1:0] GRAY_MIN = 8'd0;

endpackage

[hw/rtl/min_max_gray_stretch.sv]
`timescale 1ns / 1ps
// Scan beats (mode 0) give no result; input stays ready for the next beat.
// Emit beats (mode 1) raise out_tvalid after compare and output load when clamped or flat,
// and when divided after compare, divider operand load, product load, 8 restoring steps,
// quotient capture and output load. Input is ready again in the same cycle that out_tvalid
// rises; the output load waits for the output register to free up.
// Synchronous active-low reset clears the range to zero and drops any pending result.
module min_max_gray_stretch
  import mmgs_pkg::*;
#(
  parameter int SAMPLE_BITS = 32,
  localparam int DataW = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [DataW-1:0] in_tdata,   // sample, zero padded to whole bytes
  input  logic [1:0]       in_tuser,   // [0] mode, [1] frame_start
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,  // pixel
  output logic [0:0]       out_tuser   // [0] flat_range
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_PUT  = 2'd3;

  logic [1:0]             state_r;
  logic [SAMPLE_BITS-1:0] range_low_r;
  logic [SAMPLE_BITS-1:0] range_high_r;
  logic [SAMPLE_BITS-1:0] sample_r;
  logic [QUO_BITS-1:0]    res_pixel_r;
  logic                   res_flat_r;
  logic                   out_valid_r;
  logic [QUO_BITS-1:0]    out_pixel_r;
  logic                   out_flat_r;

  logic                   in_beat;
  logic [SAMPLE_BITS-1:0] in_sample;
  logic                   in_mode;
  logic                   in_start;
  logic                   out_free;
  logic                   out_load;
  logic                   is_flat;
  logic                   is_below;
  logic                   is_above;
  logic                   div_start;
  logic                   div_done;
  logic [QUO_BITS-1:0]    div_quo;
  logic [SAMPLE_BITS-1:0] div_num;
  logic [SAMPLE_BITS-1:0] div_den;

  assign in_tready = (state_r == ST_IDLE);
  assign in_beat   = in_tvalid && in_tready;
  assign in_sample = in_tdata[SAMPLE_BITS-1:0];
  assign in_mode   = in_tuser[0];
  assign in_start  = in_tuser[1];
  assign out_free  = !out_valid_r || out_tready;
  assign out_load  = (state_r == ST_PUT) && out_free;

  assign is_flat  = (range_high_r == range_low_r);
  assign is_below = ($signed(sample_r) <= $signed(range_low_r));
  assign is_above = ($signed(sample_r) >= $signed(range_high_r));

  assign div_start = (state_r == ST_CMP) && !is_flat && !is_below && !is_above;
  // low < sample < high here, so modular differences are exact
  assign div_num   = sample_r - range_low_r;
  assign div_den   = range_high_r - range_low_r;

  mmgs_div #(
    .W(SAMPLE_BITS)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      range_low_r  <= '0;
      range_high_r <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_beat) begin
            if (in_mode) begin
              sample_r <= in_sample;
              state_r  <= ST_CMP;
            end else if (in_start) begin
              range_low_r  <= in_sample;
              range_high_r <= in_sample;
            end else begin
              if ($signed(in_sample) < $signed(range_low_r)) begin
                range_low_r <= in_sample;
              end
              if ($signed(in_sample) > $signed(range_high_r)) begin
                range_high_r <= in_sample;
              end
            end
          end
        end
        ST_CMP: begin
          res_flat_r <= is_flat;
          priority if (is_flat || is_below) begin
            res_pixel_r <= GRAY_MIN;
            state_r     <= ST_PUT;
          end else if (is_above) begin
            res_pixel_r <= GRAY_MAX;
            state_r     <= ST_PUT;
          end else begin
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            res_pixel_r <= div_quo;
            state_r     <= ST_PUT;
          end
        end
        ST_PUT: begin
          // hold until the output register is free
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
      out_pixel_r <= res_pixel_r;
      out_flat_r  <= res_flat_r;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_pixel_r;
  assign out_tuser[0] = out_flat_r;

endmodule

[hw/rtl/mmgs_div.sv]
`timescale 1ns / 1ps
// Restoring divider: quo = floor(255 * num / den) for num < den, one quotient bit a cycle.
module mmgs_div
  import mmgs_pkg::*;
#(
  parameter int W = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [W-1:0]        num,
  input  logic [W-1:0]        den,
  output logic                done,
  output logic [QUO_BITS-1:0] quo
);

  localparam int NW = W + QUO_BITS;
  localparam int CW = $clog2(QUO_BITS);

  logic                busy_r;
  logic                prep_r;
  logic                done_r;
  logic [CW-1:0]       cnt_r;
  logic [W-1:0]        num_r;
  logic [W-1:0]        den_r;
  logic [W-1:0]        rem_r;
  logic [QUO_BITS-1:0] low_r;
  logic [QUO_BITS-1:0] quo_r;

  logic [NW-1:0] num_ext;
  logic [NW-1:0] prod;
  logic [W:0]    trial;
  logic [W:0]    diff;
  logic          fits;

  // 255 * num as (num << 8) - num
  assign num_ext = {{QUO_BITS{1'b0}}, num_r};
  assign prod    = (num_ext << QUO_BITS) - num_ext;
  assign trial   = {rem_r, low_r[QUO_BITS-1]};
  assign diff    = trial - {1'b0, den_r};
  assign fits    = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      prep_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        num_r  <= num;
        den_r  <= den;
        prep_r <= 1'b1;
        busy_r <= 1'b0;
      end else if (prep_r) begin
        // upper part of the product is already below den
        rem_r  <= prod[NW-1:QUO_BITS];
        low_r  <= prod[QUO_BITS-1:0];
        cnt_r  <= '0;
        prep_r <= 1'b0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= fits ? diff[W-1:0] : trial[W-1:0];
        low_r <= low_r << 1;
        quo_r <= {quo_r[QUO_BITS-2:0], fits};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(QUO_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

[test/tb_min_max_gray_stretch.sv]
`timescale 1ns / 1ps
// Self-checking testbench for min_max_gray_stretch: scans and emits beats, predicts pixels.
module tb_min_max_gray_stretch
  import mmgs_pkg::*;
;

  localparam int SAMPLE_BITS = 32;
  localparam int CYCLE_LIMIT = 500000;
  localparam int BEATS_PER_PHASE = 630;

  typedef enum bit {
    MODE_SCAN = 1'b0,
    MODE_EMIT = 1'b1
  } beat_mode_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic       flat;
  } gray_result_t;

  class stretch_scoreboard;
    logic signed [SAMPLE_BITS-1:0] range_min;
    logic signed [SAMPLE_BITS-1:0] range_max;
    gray_result_t pending_pixels[$];
    int errors;
    int scans;
    int pixels;
    int flats;

    function new();
      range_min = '0;
      range_max = '0;
      errors = 0;
      scans = 0;
      pixels = 0;
      flats = 0;
    endfunction

    function int outstanding();
      return pending_pixels.size();
    endfunction

    // Update the range on a scan beat; queue the predicted pixel on an emit beat.
    function void note_beat(beat_mode_t mode, logic signed [SAMPLE_BITS-1:0] sample,
                            bit start);
      gray_result_t want;
      longint span;
      longint offset;
      if (mode == MODE_SCAN) begin
        scans++;
        if (start) begin
          range_min = sample;
          range_max = sample;
        end else begin
          if (sample < range_min) range_min = sample;
          if (sample > range_max) range_max = sample;
        end
        return;
      end
      want.flat = 1'b0;
      if (range_max == range_min) begin
        want.pixel = GRAY_MIN;
        want.flat = 1'b1;
        flats++;
      end else if (sample <= range_min) begin
        want.pixel = GRAY_MIN;
      end else if (sample >= range_max) begin
        want.pixel = GRAY_MAX;
      end else begin
        span = longint'(range_max) - longint'(range_min);
        offset = longint'(sample) - longint'(range_min);
        want.pixel = 8'((offset * longint'(GRAY_MAX)) / span);
      end
      pending_pixels.push_back(want);
    endfunction

    function void check_pixel(logic [7:0] pixel, logic flat);
      gray_result_t want;
      if (pending_pixels.size() == 0) begin
        $error("unexpected result beat: pixel %0d flat_range %0d", pixel, flat);
        errors++;
        return;
      end
      want = pending_pixels.pop_front();
      pixels++;
      if (pixel !== want.pixel) begin
        $error("pixel mismatch: expected %0d, actual %0d", want.pixel, pixel);
        errors++;
      end
      if (flat !== want.flat) begin
        $error("flat_range mismatch: expected %0d, actual %0d", want.flat, flat);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;    // sample
  logic [1:0]  in_tuser = '0;    // [0] mode, [1] frame_start
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;        // pixel
  logic [0:0]  out_tuser;        // [0] flat_range

  stretch_scoreboard sb = new();
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int beats_sent = 0;
  int cycles = 0;

  min_max_gray_stretch #(.SAMPLE_BITS(SAMPLE_BITS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      sb.note_beat(beat_mode_t'(in_tuser[0]), $signed(in_tdata), in_tuser[1]);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_pixel(out_tdata, out_tuser[0]);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.outstanding());
      $display("FAIL");
      $finish;
    end
  end

  // Enter and leave at a falling edge; valid stays high across back-to-back beats.
  task automatic send_beat(beat_mode_t mode, logic [31:0] sample, bit start);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= sample;
    in_tuser <= {start, mode};
    do @(posedge clk); while (!in_tready);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
  endtask

  task automatic directed_beats();
    send_beat(MODE_EMIT, 32'h0000_0000, 1'b0);   // flat range straight after reset
    send_beat(MODE_SCAN, 32'h8000_0000, 1'b1);
    send_beat(MODE_SCAN, 32'h7fff_ffff, 1'b0);
    send_beat(MODE_EMIT, 32'h8000_0000, 1'b0);
    send_beat(MODE_EMIT, 32'h7fff_ffff, 1'b0);
    send_beat(MODE_EMIT, 32'h0000_0000, 1'b0);
    send_beat(MODE_EMIT, 32'h0000_0001, 1'b1);   // frame_start ignored on emit
    send_beat(MODE_SCAN, 32'd100, 1'b1);          // reload narrows range
    send_beat(MODE_EMIT, 32'd100, 1'b0);
    send_beat(MODE_SCAN, 32'd355, 1'b0);
    send_beat(MODE_EMIT, 32'd99, 1'b0);           // below range
    send_beat(MODE_EMIT, 32'd356, 1'b0);          // above range
    send_beat(MODE_EMIT, 32'd101, 1'b0);
    send_beat(MODE_EMIT, 32'd354, 1'b0);
    send_beat(MODE_SCAN, 32'hffff_fffb, 1'b0);   // widen low end to -5
    send_beat(MODE_EMIT, 32'hffff_fffb, 1'b0);
    send_beat(MODE_EMIT, 32'hffff_ffff, 1'b0);
    send_beat(MODE_SCAN, 32'd200, 1'b0);
    send_beat(MODE_EMIT, 32'd355, 1'b0);
    send_beat(MODE_EMIT, 32'haaaa_5555, 1'b1);
  endtask

  // Mostly whole frames (scan pass, then emit pass), some noise and broken frames.
  task automatic random_beats(int target);
    logic [31:0] base;
    logic [31:0] spread;
    int n_scan;
    int n_emit;
    while (beats_sent < target) begin
      if ($urandom_range(9) < 8) begin
        base = $urandom;
        case ($urandom_range(3))
          0: spread = 32'd0;
          1: spread = $urandom_range(300);
          2: spread = $urandom_range(32'h0002_0000);
          default: spread = $urandom;
        endcase
        n_scan = $urandom_range(1, 6);
        n_emit = $urandom_range(1, 8);
        for (int i = 0; i < n_scan; i++)
          send_beat(MODE_SCAN, base + $urandom_range(spread), (i == 0));
        for (int i = 0; i < n_emit; i++) begin
          if ($urandom_range(9) == 0)
            send_beat(MODE_EMIT, $urandom, 1'($urandom_range(1)));
          else
            send_beat(MODE_EMIT, base + $urandom_range(spread), 1'($urandom_range(1)));
        end
      end else begin
        n_scan = $urandom_range(1, 4);
        for (int i = 0; i < n_scan; i++)
          send_beat(beat_mode_t'($urandom_range(1)), $urandom, 1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    directed_beats();
    drain_results();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 34;
          rx_idle_pct = 64;
        end
        1: begin
          tx_idle_pct = 64;
          rx_idle_pct = 34;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      random_beats(beats_sent + BEATS_PER_PHASE);
      // hold off the sender until the block has returned every pixel
      drain_results();
    end

    repeat (16) @(negedge clk);
    $display("Sent %0d beats: %0d scans and %0d emits checked, %0d of them on a flat range.",
             beats_sent, sb.scans, sb.pixels, sb.flats);
    $display("Sender and receiver idled in turn, then both ran at full rate.");
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
